// File: hw/rtl/rpc_pkg.sv
package rpc_pkg;

  // Operation codes carried in in_tuser
  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_ADD   = 2'd1;
  localparam logic [1:0] OP_EVAL  = 2'd2;

  localparam int OP_W     = 2;
  localparam int IDX_W    = 5;   // width of an element index field
  localparam int SIZE_W   = 6;   // width of universe_size
  localparam int ROW_CAP  = 32;  // upper bound on the row count of the relation matrix
  localparam int MASK_W   = 32;  // width of the domain and codomain masks
  localparam int IN_W     = 16;
  localparam int OUT_W    = 72;

  // Output field positions inside out_tdata
  localparam int O_REFL   = 0;
  localparam int O_SYM    = 1;
  localparam int O_ANTI   = 2;
  localparam int O_TRANS  = 3;
  localparam int O_FUNC   = 4;
  localparam int O_DOM    = 5;
  localparam int O_COD    = 37;
  localparam int O_ERR    = 69;

  typedef struct packed {
    logic             accept;    // request taken this cycle
    logic             add_wr;    // write back the merged row of an add
    logic             ev_init;   // preset evaluation flags
    logic             ev_load;   // latch the current row from the read port
    logic             ev_acc;    // fold the read row into the current row's checks
    logic             ev_fin;    // close the current row
    logic             out_load;  // move the flags into the output register
    logic             rd_in;     // read address comes from the incoming request
    logic [IDX_W-1:0] rd_idx;
    logic [IDX_W-1:0] row_idx;
  } rpc_cmd_t;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic             n_zero;
    logic [IDX_W-1:0] last;      // highest index of the active universe
    logic             out_busy;  // output register holds an untaken result
  } rpc_sts_t;

endpackage

// File: hw/rtl/rpc_ram.sv
module rpc_ram #(
  parameter int W = 32,
  parameter int D = 32
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hw/rtl/rpc_ctrl.sv
module rpc_ctrl #(
  parameter int ROWS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  rpc_pkg::rpc_sts_t sts,
  output rpc_pkg::rpc_cmd_t cmd
);
  import rpc_pkg::*;

  localparam int IW = $clog2(ROWS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ADD  = 3'd1;
  localparam logic [2:0] S_ROW  = 3'd2;
  localparam logic [2:0] S_LOAD = 3'd3;
  localparam logic [2:0] S_COL  = 3'd4;
  localparam logic [2:0] S_TAIL = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_OUT  = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [IW-1:0] i_r, i_nxt;
  logic [IW-1:0] j_r, j_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt   = state_r;
    i_nxt       = i_r;
    j_nxt       = j_r;
    cmd         = '0;
    cmd.row_idx = IDX_W'(i_r);
    case (state_r)
      S_IDLE: begin
        cmd.rd_in  = 1'b1;
        cmd.accept = in_tvalid;
        if (in_tvalid) begin
          case (sts.op)
            OP_ADD: state_nxt = S_ADD;
            OP_EVAL: begin
              cmd.ev_init = 1'b1;
              i_nxt       = '0;
              state_nxt   = sts.n_zero ? S_OUT : S_ROW;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        cmd.add_wr = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_ROW: begin
        cmd.rd_idx = IDX_W'(i_r);
        state_nxt  = S_LOAD;
      end
      S_LOAD: begin
        cmd.ev_load = 1'b1;
        cmd.rd_idx  = '0;
        if (sts.last == '0) begin
          state_nxt = S_TAIL;
        end else begin
          j_nxt     = IW'(1);
          state_nxt = S_COL;
        end
      end
      S_COL: begin
        cmd.ev_acc = 1'b1;
        cmd.rd_idx = IDX_W'(j_r);
        if (IDX_W'(j_r) == sts.last) begin
          state_nxt = S_TAIL;
        end else begin
          j_nxt = j_r + IW'(1);
        end
      end
      S_TAIL: begin
        cmd.ev_acc = 1'b1;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        cmd.ev_fin = 1'b1;
        if (IDX_W'(i_r) == sts.last) begin
          state_nxt = S_OUT;
        end else begin
          i_nxt     = i_r + IW'(1);
          state_nxt = S_ROW;
        end
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      i_r     <= '0;
      j_r     <= '0;
    end else begin
      state_r <= state_nxt;
      i_r     <= i_nxt;
      j_r     <= j_nxt;
    end
  end

  // never overwrite a result that is still waiting
  a_out_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> !sts.out_busy)
    else $error("result loaded over a pending result");

  a_add_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && sts.op == OP_ADD) |=> (state_r == S_ADD))
    else $error("add request not followed by write back");

  a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_COL) |-> (IDX_W'(j_r) <= sts.last))
    else $error("column walk past the universe");

endmodule

// File: hw/rtl/rpc_dp.sv
module rpc_dp #(
  parameter int ROWS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [rpc_pkg::IN_W-1:0]   in_tdata,
  input  logic [rpc_pkg::OP_W-1:0]   in_tuser,
  input  logic                       cfg_valid,
  input  logic [rpc_pkg::SIZE_W-1:0] cfg_data,
  output logic [rpc_pkg::OUT_W-1:0]  out_tdata,
  output logic                       out_tvalid,
  input  logic                       out_tready,
  input  rpc_pkg::rpc_cmd_t          cmd,
  output rpc_pkg::rpc_sts_t          sts
);
  import rpc_pkg::*;

  localparam int IW = $clog2(ROWS);

  logic [SIZE_W-1:0] size_r;
  logic [SIZE_W-1:0] n;
  logic [ROWS-1:0]   m;
  logic [ROWS-1:0]   valid_r;
  logic              err_r;

  logic [IDX_W-1:0]  in_left;
  logic [IDX_W-1:0]  in_right;
  logic              in_range;
  logic [IW-1:0]     left_r;
  logic [IW-1:0]     right_r;
  logic              add_ok_r;

  logic [IW-1:0]     raddr;
  logic [IW-1:0]     rd_q_r;
  logic [ROWS-1:0]   rdata;
  logic [ROWS-1:0]   row_cur;
  logic [ROWS-1:0]   wdata;
  logic              we;
  logic [IW-1:0]     ii;

  logic [ROWS-1:0]   r_r;
  logic [ROWS-1:0]   reach_r;
  logic [ROWS-1:0]   dom_r;
  logic [ROWS-1:0]   cod_r;
  logic              refl_r, sym_r, anti_r, trans_r, func_r;

  logic [OUT_W-1:0]  out_r;
  logic [OUT_W-1:0]  out_nxt;
  logic              out_valid_r;

  // saturate the universe to the matrix size
  assign n = (size_r > SIZE_W'(ROWS)) ? SIZE_W'(ROWS) : size_r;

  always_comb begin
    for (int k = 0; k < ROWS; k++) begin
      m[k] = (SIZE_W'(k) < n);
    end
  end

  assign in_left  = in_tdata[IDX_W-1:0];
  assign in_right = in_tdata[2*IDX_W-1:IDX_W];
  assign in_range = ({1'b0, in_left} < n) && ({1'b0, in_right} < n);

  assign sts.op       = in_tuser;
  assign sts.n_zero   = (n == '0);
  assign sts.last     = sts.n_zero ? '0 : IDX_W'(n - SIZE_W'(1));
  assign sts.out_busy = out_valid_r && !out_tready;

  assign raddr   = cmd.rd_in ? in_left[IW-1:0] : cmd.rd_idx[IW-1:0];
  assign ii      = cmd.row_idx[IW-1:0];
  assign row_cur = valid_r[rd_q_r] ? (rdata & m) : '0;

  // merge the new pair into the row read during acceptance
  assign we    = cmd.add_wr && add_ok_r;
  assign wdata = (valid_r[left_r] ? rdata : '0) | (ROWS'(1) << right_r);

  rpc_ram #(.W(ROWS), .D(ROWS)) u_matrix (
    .clk   (clk),
    .we    (we),
    .waddr (left_r),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    rd_q_r <= raddr;
    if (cmd.accept) begin
      left_r  <= in_left[IW-1:0];
      right_r <= in_right[IW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r   <= SIZE_W'(32);
      valid_r  <= '0;
      err_r    <= 1'b0;
      add_ok_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        size_r <= cfg_data;
      end
      if (cmd.accept && in_tuser == OP_CLEAR) begin
        valid_r <= '0;
        err_r   <= 1'b0;
      end
      if (cmd.accept && in_tuser == OP_ADD) begin
        add_ok_r <= in_range;
        if (!in_range) begin
          err_r <= 1'b1;
        end
      end
      if (we) begin
        valid_r[left_r] <= 1'b1;
      end
    end
  end

  // evaluation accumulators
  always_ff @(posedge clk) begin
    if (cmd.ev_init) begin
      refl_r  <= 1'b1;
      sym_r   <= 1'b1;
      anti_r  <= 1'b1;
      trans_r <= 1'b1;
      func_r  <= 1'b1;
      dom_r   <= '0;
      cod_r   <= '0;
    end
    if (cmd.ev_load) begin
      r_r     <= row_cur;
      reach_r <= '0;
      if (!row_cur[ii]) begin
        refl_r <= 1'b0;
      end
      if ((row_cur & (row_cur - ROWS'(1))) != '0) begin
        func_r <= 1'b0;
      end
      dom_r[ii] <= |row_cur;
      cod_r     <= cod_r | row_cur;
    end
    if (cmd.ev_acc && r_r[rd_q_r]) begin
      if (!row_cur[ii]) begin
        sym_r <= 1'b0;
      end else if (rd_q_r != ii) begin
        anti_r <= 1'b0;
      end
      reach_r <= reach_r | row_cur;
    end
    if (cmd.ev_fin && ((reach_r & ~r_r) != '0)) begin
      trans_r <= 1'b0;
    end
  end

  always_comb begin
    out_nxt                  = '0;
    out_nxt[O_REFL]          = refl_r;
    out_nxt[O_SYM]           = sym_r;
    out_nxt[O_ANTI]          = anti_r;
    out_nxt[O_TRANS]         = trans_r;
    out_nxt[O_FUNC]          = func_r;
    out_nxt[O_DOM +: MASK_W] = MASK_W'(dom_r);
    out_nxt[O_COD +: MASK_W] = MASK_W'(cod_r);
    out_nxt[O_ERR]           = err_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_tdata  = out_r;
  assign out_tvalid = out_valid_r;

  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && in_tuser == OP_CLEAR) |=> (valid_r == '0 && !err_r))
    else $error("clear left rows or error flag set");

  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.accept && in_tuser == OP_ADD && !in_range) |=> (err_r && !add_ok_r))
    else $error("out-of-universe pair not flagged");

endmodule

// File: hw/rtl/relation_property_checker.sv
// Binary relation property checker. Requests arrive on in_* with the operation in
// in_tuser (clear, add pair, evaluate); only an evaluation returns a result on out_*.
// A clear is done at acceptance, and an add reads the left row at acceptance, then
// writes back the merged row through the write port of the row memory. An evaluation
// walks the matrix row by row: row i is read, then every row j of the universe. The
// result sits in an output register, so a new request is taken while it waits; a
// second evaluation holds in its output state until the first result is taken.
// universe_size is written on cfg_* and saturates at the matrix size.
module relation_property_checker #(
  parameter int MAX_ELEMENTS = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [rpc_pkg::IN_W-1:0]   in_tdata,   // left_index, right_index
  input  logic [rpc_pkg::OP_W-1:0]   in_tuser,   // operation
  output logic                       out_tvalid,
  input  logic                       out_tready,
  // is_reflexive, is_symmetric, is_antisymmetric, is_transitive, is_function,
  // domain_mask, codomain_mask, range_error
  output logic [rpc_pkg::OUT_W-1:0]  out_tdata,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [rpc_pkg::SIZE_W-1:0] cfg_data    // universe_size
);
  import rpc_pkg::*;

  localparam int ROWS = (MAX_ELEMENTS < ROW_CAP) ? MAX_ELEMENTS : ROW_CAP;

  rpc_cmd_t cmd;
  rpc_sts_t sts;

  assign cfg_ready = 1'b1;

  rpc_ctrl #(.ROWS(ROWS)) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rpc_dp #(.ROWS(ROWS)) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .out_tdata  (out_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule
